@@ hdl/http_chunked_encoder_top_assert.svh @@
// assertion macros used by the checker file
`ifndef HTTP_CHUNKED_ENCODER_TOP_ASSERT_SVH
`define HTTP_CHUNKED_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define HCE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define HCE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/hce_pkg.sv @@
`timescale 1ns / 1ps

package hce_pkg;

   // chunk buffer geometry
   localparam int BUFFER_BYTES = 32;
   localparam int ADDR_W       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int FILL_W       = 6;
   localparam int CS_W         = 6;
   localparam logic [CS_W-1:0] CS_RESET = CS_W'(32);

   // stream characters
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_A    = 8'h61;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_FLUSH  = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_CLOSE  = 2'd3
   } cmd_type;

   // what the output register loads
   typedef enum logic [2:0] {
      SEL_NONE,
      SEL_HEX_HI,
      SEL_HEX_LO,
      SEL_CR,
      SEL_LF,
      SEL_DATA,
      SEL_ZERO,
      SEL_REJECT
   } sel_type;

   // controller to datapath
   typedef struct packed {
      logic    emit;
      sel_type sel;
      logic    last;
      logic    flush;
      logic    wr_buf;
      logic    rd_next;
      logic    clr_fill;
      logic    set_closed;
      logic    set_closing;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic closed;
      logic closing_sent;
      logic fill_nz;
      logic write_emits;
      logic hi_nz;
      logic data_last;
   } dp_stat_type;

   // lowercase hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CHAR_ZERO + {4'd0, d};
      end else begin
         r = CHAR_A + {4'd0, d} - 8'd10;
      end
      return r;
   endfunction

endpackage

@@ hdl/hce_ifs.sv @@
`timescale 1ns / 1ps

// command channel
interface hce_req_if;
   logic             valid;
   logic             ready;
   hce_pkg::cmd_type command;
   logic [7:0]       data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// encoded stream channel
interface hce_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       flush_out;
   logic       status;
   logic       last;

   modport source (output valid, output out_byte, output byte_valid, output flush_out,
                   output status, output last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input flush_out,
                   input status, input last, output ready);
endinterface

// chunk size register write channel
interface hce_csr_if;
   logic                         valid;
   logic                         ready;
   logic [hce_pkg::CS_W-1:0]     chunk_size;

   modport source (output valid, output chunk_size, input ready);
   modport sink   (input valid, input chunk_size, output ready);
endinterface

@@ hdl/hce_ram.sv @@
`timescale 1ns / 1ps

module hce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/hce_ctrl.sv @@
`timescale 1ns / 1ps

module hce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  hce_pkg::cmd_type     req_command,
   output logic                 req_ready,
   input  hce_pkg::dp_stat_type stat,
   output hce_pkg::ctl_cmd_type cmd
);
   import hce_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HEX_HI,
      S_HEX_LO,
      S_CR1,
      S_LF1,
      S_DATA,
      S_CR2,
      S_LF2,
      S_ZERO,
      S_CR3,
      S_LF3,
      S_CR4,
      S_LF4,
      S_FLUSH,
      S_REJECT
   } state_type;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;
   logic      flush_ff, flush_in;
   logic      do_chunk;

   assign req_ready = (state_ff == S_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      flush_in = flush_ff;
      do_chunk = 1'b0;
      cmd             = '0;
      cmd.sel         = SEL_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               fin_in   = 1'b0;
               flush_in = 1'b0;
               case (req_command)
                  CMD_WRITE: begin
                     if (stat.closed) begin
                        state_in = S_REJECT;
                     end else begin
                        cmd.wr_buf = 1'b1;
                        if (stat.write_emits) begin
                           state_in = S_HEX_HI;
                        end
                     end
                  end
                  CMD_FLUSH: begin
                     flush_in = 1'b1;
                     state_in = stat.fill_nz ? S_HEX_HI : S_FLUSH;
                  end
                  CMD_FINISH: begin
                     if (!stat.closing_sent) begin
                        fin_in   = 1'b1;
                        state_in = stat.fill_nz ? S_HEX_HI : S_ZERO;
                     end
                  end
                  CMD_CLOSE: begin
                     if (!stat.closed) begin
                        cmd.set_closed = 1'b1;
                        flush_in       = 1'b1;
                        fin_in         = !stat.closing_sent;
                        do_chunk       = stat.fill_nz && !stat.closing_sent;
                        if (do_chunk) begin
                           state_in = S_HEX_HI;
                        end else if (!stat.closing_sent) begin
                           state_in = S_ZERO;
                        end else begin
                           state_in = S_FLUSH;
                        end
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_HEX_HI: begin
            // high digit only when the count needs it
            if (!stat.hi_nz) begin
               state_in = S_HEX_LO;
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_HEX_HI;
               state_in = S_HEX_LO;
            end
         end
         S_HEX_LO: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_HEX_LO;
               state_in = S_CR1;
            end
         end
         S_CR1: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_CR;
               state_in = S_LF1;
            end
         end
         S_LF1: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_LF;
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.sel     = SEL_DATA;
               cmd.rd_next = 1'b1;
               state_in    = stat.data_last ? S_CR2 : S_DATA;
            end
         end
         S_CR2: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_CR;
               state_in = S_LF2;
            end
         end
         S_LF2: begin
            if (stat.out_free) begin
               cmd.emit     = 1'b1;
               cmd.sel      = SEL_LF;
               cmd.clr_fill = 1'b1;
               state_in     = fin_ff ? S_ZERO : S_IDLE;
            end
         end
         S_ZERO: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_ZERO;
               state_in = S_CR3;
            end
         end
         S_CR3: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_CR;
               state_in = S_LF3;
            end
         end
         S_LF3: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_LF;
               state_in = S_CR4;
            end
         end
         S_CR4: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_CR;
               state_in = S_LF4;
            end
         end
         S_LF4: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.sel         = SEL_LF;
               cmd.set_closing = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_NONE;
               state_in = S_IDLE;
            end
         end
         S_REJECT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_REJECT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a beat is the final one when the sequence ends with it
      cmd.last  = (state_in == S_IDLE);
      cmd.flush = flush_ff;
   end

   // state and sequence flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fin_ff   <= 1'b0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         flush_ff <= flush_in;
      end
   end

endmodule

@@ hdl/hce_datapath.sv @@
`timescale 1ns / 1ps

module hce_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                req_data_byte,
   input  logic                      csr_write,
   input  logic [hce_pkg::CS_W-1:0]  csr_chunk_size,
   input  hce_pkg::ctl_cmd_type      cmd,
   output hce_pkg::dp_stat_type      stat,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_flush_out,
   output logic                      rsp_status,
   output logic                      rsp_last
);
   import hce_pkg::*;

   logic [CS_W-1:0]   chunk_size_ff;
   logic [CS_W-1:0]   eff_size;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_wr;
   logic [FILL_W-1:0] idx_ff;
   logic [FILL_W-1:0] idx_inc;
   logic              fill_room;
   logic              closed_ff;
   logic              closing_ff;
   logic              buf_wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic [7:0]        byte_in;
   logic              rsp_valid_ff;
   logic [7:0]        out_byte_ff;
   logic              byte_valid_ff;
   logic              flush_out_ff;
   logic              status_ff;
   logic              last_ff;

   // chunk size clamped to the buffer, zero taken as one
   always_comb begin
      if (chunk_size_ff == '0) begin
         eff_size = CS_W'(1);
      end else if (chunk_size_ff > CS_W'(BUFFER_BYTES)) begin
         eff_size = CS_W'(BUFFER_BYTES);
      end else begin
         eff_size = chunk_size_ff;
      end
   end

   // fill level after an incoming write
   assign fill_room = (fill_ff < FILL_W'(BUFFER_BYTES));
   assign fill_wr   = fill_room ? fill_ff + FILL_W'(1) : fill_ff;
   assign buf_wr    = cmd.wr_buf && fill_room;
   assign idx_inc   = idx_ff + FILL_W'(1);

   // read one ahead so a data byte goes out every cycle while the output register is free
   assign rd_addr = cmd.rd_next ? idx_inc[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];

   hce_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_buf (
      .clock   (clock),
      .wr_en   (buf_wr),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // status toward the controller
   always_comb begin
      stat.out_free     = !rsp_valid_ff || rsp_ready;
      stat.closed       = closed_ff;
      stat.closing_sent = closing_ff;
      stat.fill_nz      = (fill_ff != '0);
      stat.write_emits  = (fill_wr >= FILL_W'(eff_size));
      stat.hi_nz        = (fill_ff[FILL_W-1:4] != '0);
      stat.data_last    = (idx_inc == fill_ff);
   end

   // stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= CS_RESET;
         fill_ff       <= '0;
         idx_ff        <= '0;
         closed_ff     <= 1'b0;
         closing_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            chunk_size_ff <= csr_chunk_size;
         end
         if (buf_wr) begin
            fill_ff <= fill_wr;
         end
         if (cmd.clr_fill) begin
            fill_ff <= '0;
            idx_ff  <= '0;
         end else if (cmd.rd_next) begin
            idx_ff <= idx_inc;
         end
         if (cmd.set_closed) begin
            closed_ff <= 1'b1;
         end
         if (cmd.set_closing) begin
            closing_ff <= 1'b1;
         end
      end
   end

   // byte select for the next beat
   always_comb begin
      case (cmd.sel)
         SEL_HEX_HI: byte_in = hex_char({2'b00, fill_ff[FILL_W-1:4]});
         SEL_HEX_LO: byte_in = hex_char(fill_ff[3:0]);
         SEL_CR:     byte_in = CHAR_CR;
         SEL_LF:     byte_in = CHAR_LF;
         SEL_DATA:   byte_in = rd_data;
         SEL_ZERO:   byte_in = CHAR_ZERO;
         default:    byte_in = 8'd0;
      endcase
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff   <= byte_in;
         byte_valid_ff <= (cmd.sel != SEL_NONE) && (cmd.sel != SEL_REJECT);
         status_ff     <= (cmd.sel == SEL_REJECT);
         last_ff       <= cmd.last;
         flush_out_ff  <= cmd.last && cmd.flush;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_flush_out  = flush_out_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

endmodule

@@ hdl/http_chunked_encoder_top.sv @@
`timescale 1ns / 1ps

// channel   dir  payload                                            beat on
// req_bus   in   command, data_byte                                 valid & ready
// rsp_bus   out  out_byte, byte_valid, flush_out, status, last      valid & ready
// csr_bus   in   chunk_size                                         valid & ready
//
// one command at a time; req_bus.ready is high only between commands
// a chunk goes out as length digits, CR LF, data, CR LF, passing through the high digit step
// whether or not the high length digit is sent, the closing chunk as 0 CR LF CR LF; while
// rsp_bus is ready the output register hands out one stream byte per cycle and the buffer is
// read one byte a cycle; rsp_bus stalls hold the sequencer in place; csr_bus is always ready
// synchronous reset clears the fill level and the closed and closing flags, chunk_size to 32

module http_chunked_encoder_top (
   input  logic             clock,
   input  logic             reset,
   hce_req_if.sink          req_bus,
   hce_rsp_if.source        rsp_bus,
   hce_csr_if.sink          csr_bus
);
   import hce_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   assign csr_bus.ready = 1'b1;

   hce_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   hce_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_bus.data_byte),
      .csr_write      (csr_bus.valid),
      .csr_chunk_size (csr_bus.chunk_size),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_out_byte   (rsp_bus.out_byte),
      .rsp_byte_valid (rsp_bus.byte_valid),
      .rsp_flush_out  (rsp_bus.flush_out),
      .rsp_status     (rsp_bus.status),
      .rsp_last       (rsp_bus.last)
   );

endmodule

@@ hdl/hce_checker.sv @@
`timescale 1ns / 1ps
`include "http_chunked_encoder_top_assert.svh"

module hce_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       byte_valid,
   input logic       flush_out,
   input logic       status,
   input logic       last
);

   // a rejected write is a single beat with no stream byte
   `HCE_ASSERT_NOW(a_reject_alone, rsp_valid && status, !byte_valid && last, "reject beat malformed")

   // the flush request rides only on the final beat
   `HCE_ASSERT_NOW(a_flush_on_last, rsp_valid && flush_out, last, "flush_out before last beat")

   // beats without a stream byte carry zero
   `HCE_ASSERT_NOW(a_empty_zero, rsp_valid && !byte_valid, out_byte == 8'd0, "empty beat nonzero")

   // a stalled beat is held
   `HCE_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(out_byte) && $stable(last), "stalled beat changed")

endmodule

bind http_chunked_encoder_top hce_checker u_hce_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .out_byte   (rsp_bus.out_byte),
   .byte_valid (rsp_bus.byte_valid),
   .flush_out  (rsp_bus.flush_out),
   .status     (rsp_bus.status),
   .last       (rsp_bus.last)
);

@@ sim/tb_http_chunked_encoder_top.sv @@
`timescale 1ns / 1ps

module tb_http_chunked_encoder_top;
   import hce_pkg::*;

   // one expected beat on the encoded stream
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       flush_out;
      logic       status;
      logic       last;
   } stream_beat_type;

   // predicts the encoded stream and checks it beat by beat
   class chunk_stream_model;
      stream_beat_type   expected_beats[$];
      logic [7:0]        chunk_bytes[BUFFER_BYTES];
      logic [FILL_W-1:0] fill_level;
      logic              closing_done;
      logic              stream_closed;
      logic [CS_W-1:0]   chunk_size;
      int                mismatches;

      function new();
         fill_level    = '0;
         closing_done  = 1'b0;
         stream_closed = 1'b0;
         chunk_size    = CS_RESET;
         mismatches    = 0;
      endfunction

      function void set_chunk_size(input logic [CS_W-1:0] value);
         chunk_size = value;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function void push_beat(input logic [7:0] b, input logic bv, input logic st);
         stream_beat_type e;
         e            = '0;
         e.out_byte   = b;
         e.byte_valid = bv;
         e.status     = st;
         expected_beats.push_back(e);
      endfunction

      function void push_crlf();
         push_beat(CHAR_CR, 1'b1, 1'b0);
         push_beat(CHAR_LF, 1'b1, 1'b0);
      endfunction

      function logic [7:0] ascii_hex(input logic [3:0] d);
         if (d < 4'd10) begin
            return CHAR_ZERO + 8'(d);
         end
         return CHAR_A + 8'(d) - 8'd10;
      endfunction

      // length in hex without leading zeros, crlf, data, crlf
      function void emit_pending();
         int i;
         if (fill_level == 0) return;
         if (fill_level >= FILL_W'(16)) begin
            push_beat(ascii_hex(4'(fill_level >> 4)), 1'b1, 1'b0);
         end
         push_beat(ascii_hex(fill_level[3:0]), 1'b1, 1'b0);
         push_crlf();
         for (i = 0; i < int'(fill_level); i++) begin
            push_beat(chunk_bytes[i], 1'b1, 1'b0);
         end
         push_crlf();
         fill_level = '0;
      endfunction

      // pending chunk then the closing chunk, only once per stream
      function void finish_stream();
         if (closing_done) return;
         emit_pending();
         push_beat(CHAR_ZERO, 1'b1, 1'b0);
         push_crlf();
         push_crlf();
         closing_done = 1'b1;
      endfunction

      function void note_command(input cmd_type cmd, input logic [7:0] b);
         int                base;
         logic              flush;
         logic [FILL_W-1:0] trigger;
         stream_beat_type   tail;
         base  = expected_beats.size();
         flush = 1'b0;
         case (cmd)
            CMD_WRITE: begin
               if (stream_closed) begin
                  push_beat(8'h00, 1'b0, 1'b1);
               end else begin
                  if (fill_level < FILL_W'(BUFFER_BYTES)) begin
                     chunk_bytes[fill_level] = b;
                     fill_level++;
                  end
                  // zero acts as one, oversize clamps to the buffer
                  if (chunk_size == '0) begin
                     trigger = FILL_W'(1);
                  end else if (chunk_size > CS_W'(BUFFER_BYTES)) begin
                     trigger = FILL_W'(BUFFER_BYTES);
                  end else begin
                     trigger = chunk_size;
                  end
                  if (fill_level >= trigger) emit_pending();
               end
            end
            CMD_FLUSH: begin
               emit_pending();
               flush = 1'b1;
            end
            CMD_FINISH: begin
               finish_stream();
            end
            default: begin
               if (!stream_closed) begin
                  stream_closed = 1'b1;
                  finish_stream();
                  flush = 1'b1;
               end
            end
         endcase
         if (flush && expected_beats.size() == base) push_beat(8'h00, 1'b0, 1'b0);
         // tag the final beat of this command
         if (expected_beats.size() > base) begin
            tail           = expected_beats.pop_back();
            tail.last      = 1'b1;
            tail.flush_out = flush;
            expected_beats.push_back(tail);
         end
      endfunction

      function void check_beat(input logic [7:0] ob, input logic bv, input logic fo,
                               input logic st, input logic la);
         stream_beat_type e;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: out_byte 8'h%02h last %b", ob, la);
            mismatches++;
            return;
         end
         e = expected_beats.pop_front();
         if (ob !== e.out_byte) begin
            $error("out_byte: expected 8'h%02h, got 8'h%02h", e.out_byte, ob);
            mismatches++;
         end
         if (bv !== e.byte_valid) begin
            $error("byte_valid: expected %b, got %b", e.byte_valid, bv);
            mismatches++;
         end
         if (fo !== e.flush_out) begin
            $error("flush_out: expected %b, got %b", e.flush_out, fo);
            mismatches++;
         end
         if (st !== e.status) begin
            $error("status: expected %b, got %b", e.status, st);
            mismatches++;
         end
         if (la !== e.last) begin
            $error("last: expected %b, got %b", e.last, la);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   hce_req_if req_bus ();
   hce_rsp_if rsp_bus ();
   hce_csr_if csr_bus ();

   http_chunked_encoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   chunk_stream_model encoder_pred;
   logic              req_gaps_on;
   logic              rsp_stalls_on;
   logic              finish_early;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      #25000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // gap length: mostly short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(12, 30);
   endfunction

   // data byte with the extremes weighted up
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 8'h00;
      if (r < 20) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // one command beat, after an optional gap
   task automatic send_command(input cmd_type cmd, input logic [7:0] b);
      int gap;
      gap = req_gaps_on ? idle_len() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid     = 1'b1;
      req_bus.command   = cmd;
      req_bus.data_byte = b;
      do @(posedge clock); while (!req_bus.ready);
      encoder_pred.note_command(cmd, b);
   endtask

   // let the block drain before touching the register
   task automatic wait_quiet();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (encoder_pred.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_chunk_size(input logic [CS_W-1:0] value);
      wait_quiet();
      @(negedge clock);
      csr_bus.valid      = 1'b1;
      csr_bus.chunk_size = value;
      do @(posedge clock); while (!csr_bus.ready);
      encoder_pred.set_chunk_size(value);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // result side ready with random stalls
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 3) == 0) stall_left = idle_len();
         end
      end
   end

   // check every result beat
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            encoder_pred.check_beat(rsp_bus.out_byte, rsp_bus.byte_valid,
                                    rsp_bus.flush_out, rsp_bus.status, rsp_bus.last);
         end
      end
   end

   // stimulus
   initial begin
      logic [CS_W-1:0] phase_sizes[8];
      int              p;
      int              k;
      int              r;
      encoder_pred       = new();
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_WRITE;
      req_bus.data_byte  = 8'h00;
      csr_bus.valid      = 1'b0;
      csr_bus.chunk_size = '0;
      req_gaps_on        = 1'b1;
      rsp_stalls_on      = 1'b1;
      finish_early       = 1'($urandom_range(0, 1));
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // short chunk, then flush with nothing pending
      send_command(CMD_WRITE, 8'h00);
      send_command(CMD_WRITE, 8'hFF);
      send_command(CMD_FLUSH, 8'hA5);
      send_command(CMD_FLUSH, 8'h00);
      // size lowered to the current fill level
      send_command(CMD_WRITE, 8'h80);
      write_chunk_size(CS_W'(1));
      send_command(CMD_WRITE, 8'h7F);
      send_command(CMD_WRITE, 8'h55);
      // zero acts as one
      write_chunk_size(CS_W'(0));
      send_command(CMD_WRITE, 8'hAA);
      // oversize clamps to the buffer
      write_chunk_size(CS_W'(63));
      send_command(CMD_WRITE, 8'h01);
      send_command(CMD_WRITE, 8'hFE);
      send_command(CMD_WRITE, 8'h3C);
      send_command(CMD_FLUSH, 8'hFF);
      // finish with pending data, repeated finish, write after finish
      if (finish_early) begin
         send_command(CMD_WRITE, 8'h11);
         send_command(CMD_FINISH, 8'h00);
         send_command(CMD_FINISH, 8'hFF);
         send_command(CMD_WRITE, 8'h22);
      end

      // random phases over several chunk sizes
      phase_sizes = '{CS_W'(32), CS_W'(5), CS_W'(63), CS_W'(1), CS_W'(0), CS_W'(33),
                      CS_W'(16), CS_W'($urandom_range(1, 63))};
      for (p = 0; p < 8; p++) begin
         write_chunk_size(phase_sizes[p]);
         req_gaps_on   = (p == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
         rsp_stalls_on = (p == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
         for (k = 0; k < 26; k++) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
               send_command(CMD_WRITE, pick_byte());
            end else if (r < 95 || !finish_early) begin
               send_command(CMD_FLUSH, pick_byte());
            end else begin
               send_command(CMD_FINISH, pick_byte());
            end
         end
      end

      // close, then everything after close
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      if (!finish_early) send_command(CMD_WRITE, 8'h3C);
      send_command(CMD_CLOSE, pick_byte());
      send_command(CMD_CLOSE, pick_byte());
      send_command(CMD_WRITE, 8'hC3);
      send_command(CMD_WRITE, pick_byte());
      send_command(CMD_FLUSH, pick_byte());
      send_command(CMD_FINISH, pick_byte());

      // drain and report
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (encoder_pred.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (encoder_pred.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/hce_pkg.sv
hdl/hce_ifs.sv
hdl/hce_ram.sv
hdl/hce_ctrl.sv
hdl/hce_datapath.sv
hdl/http_chunked_encoder_top.sv
hdl/hce_checker.sv
sim/tb_http_chunked_encoder_top.sv
